// File: hw/rtl/rtcr_pkg.sv
// Shared types, constants and decode helpers for the three-wire RTC time reader.
`default_nettype none

package rtcr_pkg;

  // Transaction modes
  localparam logic [1:0] ModeWrite    = 2'd0;
  localparam logic [1:0] ModeRead     = 2'd1;
  localparam logic [1:0] ModeReadTime = 2'd2;
  localparam logic [1:0] ModeUnused   = 2'd3;

  // Serial frame layout
  localparam logic [4:0] GapPosition  = 5'd16;
  localparam logic [4:0] LastBitPos   = 5'd15;
  localparam logic [4:0] DataBitPos   = 5'd8;
  localparam logic [7:0] TimeBaseCmd  = 8'h81;
  localparam logic [2:0] LastTimeIdx  = 3'd6;
  localparam logic [7:0] HalfPeriodRst = 8'd2;

  // Time register slots in read-time order
  localparam logic [2:0] IdxSecond = 3'd0;
  localparam logic [2:0] IdxMinute = 3'd1;
  localparam logic [2:0] IdxHour   = 3'd2;
  localparam logic [2:0] IdxDay    = 3'd3;
  localparam logic [2:0] IdxMonth  = 3'd4;
  localparam logic [2:0] IdxYear   = 3'd6;

  // Decode limits (value must be below)
  localparam logic [7:0] LimSecond = 8'd60;
  localparam logic [7:0] LimMinute = 8'd60;
  localparam logic [7:0] LimHour   = 8'd24;
  localparam logic [7:0] LimDay    = 8'd32;
  localparam logic [7:0] LimMonth  = 8'd13;
  localparam logic [7:0] LimYear   = 8'd100;

  // Widths of the stream words
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 48;

  // One result item, last field in the lowest bits
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
    logic [7:0] read_data;
    logic       busy_res;
    logic       io_drive;
    logic       io_out;
    logic       serial_clock;
    logic       chip_enable;
  } rtcr_result_t;

  // Two BCD digits to binary, max 165
  function automatic logic [7:0] bcd_value(input logic [7:0] b);
    logic [7:0] tens;
    tens = {4'd0, b[7:4]};
    return (tens << 3) + (tens << 1) + {4'd0, b[3:0]};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rtcr_step.sv
// Serial transfer sequencer: advances the line state once per accepted tick item.
`default_nettype none

module rtcr_step
  import rtcr_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  wire logic         start_req_i,
  input  wire logic [1:0]   mode_i,
  input  wire logic [7:0]   reg_address_i,
  input  wire logic [7:0]   write_data_i,
  input  wire logic         io_in_i,
  input  wire logic [7:0]   half_period_i,
  output rtcr_result_t      result_o
);

  logic [7:0] tick_div_q, tick_div_d;
  logic [4:0] bit_pos_q, bit_pos_d;
  logic [7:0] shift_q, shift_d;
  logic [2:0] reg_idx_q, reg_idx_d;
  logic [1:0] mode_q, mode_d;
  logic       busy_q, busy_d;
  logic       clk_lvl_q, clk_lvl_d;
  logic       en_q, en_d;
  logic [7:0] rx_q, rx_d;
  logic [7:0] latch_q, latch_d;
  logic [6:0] year_q, year_d;
  logic [3:0] month_q, month_d;
  logic [4:0] day_q, day_d;
  logic [4:0] hour_q, hour_d;
  logic [5:0] minute_q, minute_d;
  logic [5:0] second_q, second_d;

  logic [7:0] half;
  logic [8:0] tick_inc;
  logic [4:0] pos_inc;
  logic [7:0] bcd;
  logic       drive;

  assign half     = (half_period_i == 8'd0) ? 8'd1 : half_period_i;
  assign tick_inc = {1'b0, tick_div_q} + 9'd1;
  assign pos_inc  = bit_pos_q + 5'd1;
  assign bcd      = bcd_value(shift_q);

  // Next state for one tick
  always_comb begin
    tick_div_d = tick_div_q;
    bit_pos_d  = bit_pos_q;
    shift_d    = shift_q;
    reg_idx_d  = reg_idx_q;
    mode_d     = mode_q;
    busy_d     = busy_q;
    clk_lvl_d  = clk_lvl_q;
    en_d       = en_q;
    rx_d       = rx_q;
    latch_d    = latch_q;
    year_d     = year_q;
    month_d    = month_q;
    day_d      = day_q;
    hour_d     = hour_q;
    minute_d   = minute_q;
    second_d   = second_q;

    if (!busy_q) begin
      // Launch a transaction; mode 3 is dropped
      if (start_req_i && mode_i != ModeUnused) begin
        mode_d     = mode_i;
        busy_d     = 1'b1;
        en_d       = 1'b1;
        clk_lvl_d  = 1'b0;
        bit_pos_d  = 5'd0;
        tick_div_d = 8'd0;
        reg_idx_d  = 3'd0;
        latch_d    = write_data_i;
        shift_d    = (mode_i == ModeReadTime) ? TimeBaseCmd : reg_address_i;
      end
    end else if (tick_inc >= {1'b0, half}) begin
      tick_div_d = 8'd0;
      if (bit_pos_q == GapPosition) begin
        // Gap over: begin next time register read
        en_d      = 1'b1;
        bit_pos_d = 5'd0;
        clk_lvl_d = 1'b0;
        shift_d   = TimeBaseCmd + {4'd0, reg_idx_q, 1'b0};
      end else if (!clk_lvl_q) begin
        // End of low half: sample read bits, raise clock
        if (bit_pos_q >= DataBitPos && mode_q != ModeWrite) begin
          shift_d = {io_in_i, shift_q[7:1]};
        end
        clk_lvl_d = 1'b1;
      end else if (bit_pos_q < LastBitPos) begin
        // End of high half: advance to next bit
        bit_pos_d = pos_inc;
        clk_lvl_d = 1'b0;
        if (pos_inc == DataBitPos) begin
          shift_d = (mode_q == ModeWrite) ? latch_q : 8'd0;
        end else if (pos_inc < DataBitPos || mode_q == ModeWrite) begin
          shift_d = {1'b0, shift_q[7:1]};
        end
      end else begin
        // Transfer complete
        clk_lvl_d = 1'b0;
        en_d      = 1'b0;
        if (mode_q == ModeReadTime) begin
          case (reg_idx_q)
            IdxSecond: if (bcd < LimSecond) second_d = bcd[5:0];
            IdxMinute: if (bcd < LimMinute) minute_d = bcd[5:0];
            IdxHour:   if (bcd < LimHour)   hour_d   = bcd[4:0];
            IdxDay:    if (bcd < LimDay)    day_d    = bcd[4:0];
            IdxMonth:  if (bcd < LimMonth)  month_d  = bcd[3:0];
            IdxYear:   if (bcd < LimYear)   year_d   = bcd[6:0];
            default: ;
          endcase
          if (reg_idx_q >= LastTimeIdx) begin
            busy_d    = 1'b0;
            bit_pos_d = 5'd0;
          end else begin
            reg_idx_d = reg_idx_q + 3'd1;
            bit_pos_d = GapPosition;
          end
        end else begin
          if (mode_q == ModeRead) rx_d = shift_q;
          busy_d    = 1'b0;
          bit_pos_d = 5'd0;
        end
      end
    end else begin
      tick_div_d = tick_inc[7:0];
    end
  end

  // Hold state; advance on each accepted tick item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_div_q <= '0;
      bit_pos_q  <= '0;
      shift_q    <= '0;
      reg_idx_q  <= '0;
      mode_q     <= '0;
      busy_q     <= 1'b0;
      clk_lvl_q  <= 1'b0;
      en_q       <= 1'b0;
      rx_q       <= '0;
      latch_q    <= '0;
      year_q     <= '0;
      month_q    <= '0;
      day_q      <= '0;
      hour_q     <= '0;
      minute_q   <= '0;
      second_q   <= '0;
    end else if (step_i) begin
      tick_div_q <= tick_div_d;
      bit_pos_q  <= bit_pos_d;
      shift_q    <= shift_d;
      reg_idx_q  <= reg_idx_d;
      mode_q     <= mode_d;
      busy_q     <= busy_d;
      clk_lvl_q  <= clk_lvl_d;
      en_q       <= en_d;
      rx_q       <= rx_d;
      latch_q    <= latch_d;
      year_q     <= year_d;
      month_q    <= month_d;
      day_q      <= day_d;
      hour_q     <= hour_d;
      minute_q   <= minute_d;
      second_q   <= second_d;
    end
  end

  // Result item reflects the state after this tick
  assign drive = busy_d && (bit_pos_d < GapPosition) &&
                 ((bit_pos_d < DataBitPos) || (mode_d == ModeWrite));

  always_comb begin
    result_o.chip_enable  = en_d;
    result_o.serial_clock = clk_lvl_d;
    result_o.io_out       = drive & shift_d[0];
    result_o.io_drive     = drive;
    result_o.busy_res     = busy_d;
    result_o.read_data    = rx_d;
    result_o.year         = year_d;
    result_o.month        = month_d;
    result_o.day          = day_d;
    result_o.hour         = hour_d;
    result_o.minute       = minute_d;
    result_o.second       = second_d;
  end

  // Idle lines sit low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (!en_q && !clk_lvl_q))
    else $error("rtcr_step: lines active while idle");

  // Inter-read gap only inside a busy time read, chip enable low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bit_pos_q == GapPosition) |-> (busy_q && !en_q && mode_q == ModeReadTime))
    else $error("rtcr_step: bad gap state");

  // Bit position never passes the gap slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_pos_q <= GapPosition)
    else $error("rtcr_step: bit position out of range");

endmodule

`default_nettype wire

// File: hw/rtl/rtcr_obuf.sv
// Two-entry output buffer: result register plus skid stage.
`default_nettype none

module rtcr_obuf
  import rtcr_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire rtcr_result_t push_data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  wire logic         pop_ready_i,
  output rtcr_result_t      data_o
);

  logic         main_valid_q, main_valid_d;
  logic         skid_valid_q, skid_valid_d;
  rtcr_result_t main_q, main_d;
  rtcr_result_t skid_q, skid_d;
  logic         pop;

  assign pop     = main_valid_q && pop_ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  // Route pushed item to the result register or the skid stage
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  // Skid stage only fills behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("rtcr_obuf: skid full with empty result register");

  // A stalled result with a full skid keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !pop_ready_i) |=> ($stable(main_q) && skid_valid_q))
    else $error("rtcr_obuf: stalled result changed");

endmodule

`default_nettype wire

// File: hw/rtl/rtc_three_wire_time_reader_unit.sv
// Top level of the three-wire RTC master with BCD time readout.
// Usage:
//   Each item on the s_axis channel is one timing tick carrying the start
//   request, mode, command byte, write byte and the sampled data pin. Each
//   accepted item yields exactly one item on m_axis: line levels (chip
//   enable, serial clock, data out and drive enable), busy flag, last read
//   byte and the held year, month, day, hour, minute and second.
//   The serial clock holds each level for half_period_ticks items (0 acts
//   as 1); the user must write it via cfg_we_i / cfg_wdata_i while idle (unchecked).
// Throughput:
//   One item per cycle while s_axis_tready_o is high. The sequencer result is
//   formed in the accepting cycle and registered into the result register or skid.
// Reset:
//   All lines low, idle, held time values zero, half period 2.
// Stall:
//   A two-entry output buffer keeps accepting while one result waits;
//   s_axis_tready_o drops only when both entries are full.
`default_nettype none

module rtc_three_wire_time_reader_unit
  import rtcr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [7:0]          cfg_wdata_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // start_req[0], mode[2:1], reg_address[10:3], write_data[18:11], io_in[19]
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // chip_enable[0], serial_clock[1], io_out[2], io_drive[3], busy_res[4],
  // read_data[12:5], year[19:13], month[23:20], day[28:24], hour[33:29],
  // minute[39:34], second[45:40]
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  logic [7:0]   half_period_q;
  logic         step;
  rtcr_result_t step_result;
  rtcr_result_t out_result;

  // Half period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HalfPeriodRst;
    end else if (cfg_we_i) begin
      half_period_q <= cfg_wdata_i;
    end
  end

  assign step = s_axis_tvalid_i && s_axis_tready_o;

  rtcr_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .start_req_i   (s_axis_tdata_i[0]),
    .mode_i        (s_axis_tdata_i[2:1]),
    .reg_address_i (s_axis_tdata_i[10:3]),
    .write_data_i  (s_axis_tdata_i[18:11]),
    .io_in_i       (s_axis_tdata_i[19]),
    .half_period_i (half_period_q),
    .result_o      (step_result)
  );

  rtcr_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .push_data_i (step_result),
    .ready_o     (s_axis_tready_o),
    .valid_o     (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .data_o      (out_result)
  );

  assign m_axis_tdata_o = {{(OutDataW - $bits(rtcr_result_t)){1'b0}}, out_result};

endmodule

`default_nettype wire
